// ----- rtl/rc4kg_pkg.sv -----
`timescale 1ns / 1ps

package rc4kg_pkg;

   localparam int BYTE_W                = 8;
   localparam int TABLE_AW              = 8;
   localparam int KEY_WORD_W            = 64;
   localparam int KEY_LEN_W             = 5;
   localparam int KEEP_W                = 4;
   localparam int CSR_IDX_W             = 2;
   localparam int DEFAULT_MAX_KEY_BYTES = 16;

   localparam logic [TABLE_AW-1:0]  TABLE_LAST    = '1;
   localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LEN  = CSR_IDX_W'(2);

   localparam logic CMD_SCHEDULE = 1'b0;
   localparam logic CMD_NEXT     = 1'b1;

   // low keep bits set, saturating at a full byte
   function automatic logic [BYTE_W-1:0] keep_mask(input logic [KEEP_W-1:0] keep);
      logic [BYTE_W-1:0] ones;
      begin
         ones = '0;
         if (keep >= KEEP_W'(BYTE_W)) begin
            keep_mask = '1;
         end else begin
            ones      = BYTE_W'(1) << keep;
            keep_mask = ones - BYTE_W'(1);
         end
      end
   endfunction

endpackage

// ----- rtl/rc4kg_ram.sv -----
`timescale 1ns / 1ps

module rc4kg_ram import rc4kg_pkg::*; #(
   parameter int DATA_W = BYTE_W,
   parameter int ADDR_W = TABLE_AW
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rc4_keystream_generator.sv -----
`timescale 1ns / 1ps

// RC4 keystream generator. The 256-byte permutation lives in a single RAM with one read
// and one write port and a registered read. A next command (req_command = 1) runs
// read s[i], read s[j], then a swap with two writes while s[i]+s[j] is read back with
// forwarding; a new request is taken only after the previous result has gone to the
// output register. A schedule command (req_command = 0) rewrites the table as the
// identity, then runs 256 swap steps (read s[m], read s[j], two writes) and answers
// with rsp_schedule_done = 1. The key is taken from the csr registers at the time of
// the schedule; keystream bytes before the first schedule are undefined.
module rc4_keystream_generator import rc4kg_pkg::*; #(
   parameter int MAX_KEY_BYTES = DEFAULT_MAX_KEY_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [KEEP_W-1:0]     req_keep_bits,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BYTE_W-1:0]     rsp_keystream_byte,
   output logic                  rsp_schedule_done,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [KEY_WORD_W-1:0] csr_data
);

   localparam int KPW       = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int KEY_SLOTS = 1 << KPW;
   localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_FILL = 4'd1;
   localparam logic [3:0] ST_K_RD = 4'd2;
   localparam logic [3:0] ST_K_J  = 4'd3;
   localparam logic [3:0] ST_K_W1 = 4'd4;
   localparam logic [3:0] ST_K_W2 = 4'd5;
   localparam logic [3:0] ST_G_J  = 4'd6;
   localparam logic [3:0] ST_G_W1 = 4'd7;
   localparam logic [3:0] ST_G_W2 = 4'd8;
   localparam logic [3:0] ST_OUT  = 4'd9;

   logic [3:0]            state_ff, state_in;
   logic [TABLE_AW-1:0]   m_ff, m_in;
   logic [TABLE_AW-1:0]   i_ff, i_in;
   logic [TABLE_AW-1:0]   j_ff, j_in;
   logic [KPW-1:0]        kpos_ff, kpos_in;
   logic [BYTE_W-1:0]     si_ff, si_in;
   logic [BYTE_W-1:0]     sj_ff, sj_in;
   logic [BYTE_W-1:0]     mask_ff, mask_in;
   logic                  teqi_ff, teqi_in;
   logic                  teqj_ff, teqj_in;
   logic [BYTE_W-1:0]     hold_byte_ff, hold_byte_in;
   logic                  hold_done_ff, hold_done_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     rsp_byte_ff, rsp_byte_in;
   logic                  rsp_done_ff, rsp_done_in;
   logic [KEY_WORD_W-1:0] key_low_ff, key_high_ff;
   logic [KEY_LEN_W-1:0]  key_length_ff;

   logic                  mem_re;
   logic [TABLE_AW-1:0]   mem_raddr;
   logic [BYTE_W-1:0]     mem_rdata;
   logic                  mem_we;
   logic [TABLE_AW-1:0]   mem_waddr;
   logic [BYTE_W-1:0]     mem_wdata;

   logic [2*KEY_WORD_W-1:0] key_all;
   logic [BYTE_W-1:0]       key_bytes [KEY_SLOTS];
   logic [KEY_LEN_W-1:0]    len_used;
   logic [KEY_LEN_W-1:0]    kpos_inc;
   logic [KPW-1:0]          kpos_wrap;
   logic [TABLE_AW-1:0]     ksa_j;
   logic [TABLE_AW-1:0]     prga_j;
   logic [TABLE_AW-1:0]     t_addr;
   logic [BYTE_W-1:0]       fwd_byte;
   logic                    out_free;
   logic                    finish;
   logic [BYTE_W-1:0]       res_byte;
   logic                    res_done;

   rc4kg_ram #(
      .DATA_W (BYTE_W),
      .ADDR_W (TABLE_AW)
   ) u_sbox (
      .clock   (clock),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata)
   );

   assign key_all = {key_high_ff, key_low_ff};

   for (genvar b = 0; b < KEY_SLOTS; b++) begin : g_key
      assign key_bytes[b] = key_all[b*BYTE_W +: BYTE_W];
   end

   always_comb begin
      priority if (key_length_ff == '0) begin
         len_used = KEY_LEN_W'(1);
      end else if (key_length_ff > MAX_LEN) begin
         len_used = MAX_LEN;
      end else begin
         len_used = key_length_ff;
      end
   end

   assign kpos_inc  = {{(KEY_LEN_W-KPW){1'b0}}, kpos_ff} + KEY_LEN_W'(1);
   assign kpos_wrap = (kpos_inc >= len_used) ? '0 : kpos_inc[KPW-1:0];

   assign ksa_j    = j_ff + mem_rdata + key_bytes[kpos_ff];
   assign prga_j   = j_ff + mem_rdata;
   assign t_addr   = si_ff + mem_rdata;
   assign fwd_byte = teqj_ff ? si_ff : (teqi_ff ? sj_ff : mem_rdata);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      m_in         = m_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      kpos_in      = kpos_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      mask_in      = mask_ff;
      teqi_in      = teqi_ff;
      teqj_in      = teqj_ff;
      hold_byte_in = hold_byte_ff;
      hold_done_in = hold_done_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      finish       = 1'b0;
      res_byte     = '0;
      res_done     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mask_in = keep_mask(req_keep_bits);
               if (req_command == CMD_NEXT) begin
                  i_in      = i_ff + TABLE_AW'(1);
                  mem_re    = 1'b1;
                  mem_raddr = i_ff + TABLE_AW'(1);
                  state_in  = ST_G_J;
               end else begin
                  m_in     = '0;
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = m_ff;
            mem_wdata = m_ff;
            m_in      = m_ff + TABLE_AW'(1);
            if (m_ff == TABLE_LAST) begin
               j_in     = '0;
               kpos_in  = '0;
               state_in = ST_K_RD;
            end
         end
         ST_K_RD: begin
            mem_re    = 1'b1;
            mem_raddr = m_ff;
            state_in  = ST_K_J;
         end
         ST_K_J: begin
            si_in     = mem_rdata;
            j_in      = ksa_j;
            mem_re    = 1'b1;
            mem_raddr = ksa_j;
            state_in  = ST_K_W1;
         end
         ST_K_W1: begin
            sj_in     = mem_rdata;
            mem_we    = 1'b1;
            mem_waddr = m_ff;
            mem_wdata = mem_rdata;
            state_in  = ST_K_W2;
         end
         ST_K_W2: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = si_ff;
            kpos_in   = kpos_wrap;
            m_in      = m_ff + TABLE_AW'(1);
            if (m_ff == TABLE_LAST) begin
               finish   = 1'b1;
               res_byte = '0;
               res_done = 1'b1;
               i_in     = '0;
               j_in     = '0;
            end else begin
               state_in = ST_K_RD;
            end
         end
         ST_G_J: begin
            si_in     = mem_rdata;
            j_in      = prga_j;
            mem_re    = 1'b1;
            mem_raddr = prga_j;
            state_in  = ST_G_W1;
         end
         ST_G_W1: begin
            // table read of s[i]+s[j] sees the pre-swap contents, fixed up next cycle
            sj_in     = mem_rdata;
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = mem_rdata;
            mem_re    = 1'b1;
            mem_raddr = t_addr;
            teqi_in   = (t_addr == i_ff);
            teqj_in   = (t_addr == j_ff);
            state_in  = ST_G_W2;
         end
         ST_G_W2: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = si_ff;
            finish    = 1'b1;
            res_byte  = fwd_byte & mask_ff;
            res_done  = 1'b0;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = hold_byte_ff;
               rsp_done_in  = hold_done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = res_byte;
            rsp_done_in  = res_done;
            state_in     = ST_IDLE;
         end else begin
            hold_byte_in = res_byte;
            hold_done_in = res_done;
            state_in     = ST_OUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff         <= m_in;
      kpos_ff      <= kpos_in;
      si_ff        <= si_in;
      sj_ff        <= sj_in;
      mask_ff      <= mask_in;
      teqi_ff      <= teqi_in;
      teqj_ff      <= teqj_in;
      hold_byte_ff <= hold_byte_in;
      hold_done_ff <= hold_done_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_done_ff  <= rsp_done_in;
   end

   // csr write transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         key_length_ff <= KEY_LEN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_LOW:  key_low_ff    <= csr_data;
            CSR_KEY_HIGH: key_high_ff   <= csr_data;
            CSR_KEY_LEN:  key_length_ff <= csr_data[KEY_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready          = 1'b1;
   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_keystream_byte = rsp_byte_ff;
   assign rsp_schedule_done  = rsp_done_ff;

`ifndef SYNTHESIS
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_we)
      else $error("table write while idle");

   a_next_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command == CMD_NEXT) |-> ##3 (state_ff == ST_G_W2))
      else $error("keystream step out of sequence");

   a_sched_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_K_W2 && m_ff == TABLE_LAST) |=> (i_ff == '0 && j_ff == '0))
      else $error("indexes not cleared after key schedule");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_G_W2 || $past(state_ff) == ST_K_W2 ||
                            $past(state_ff) == ST_OUT))
      else $error("result raised outside a finishing state");
`endif

endmodule
